// ===== hw/rtl/gnel_pkg.sv =====
`default_nettype none

package gnel_pkg;

    // Default build values
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 16;

    // Window registers
    localparam int WIN_W        = 16;
    localparam int CFG_INDEX_W  = 4;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd20;

    localparam logic [CFG_INDEX_W-1:0] REG_PITCH_WIN = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_YAW_WIN   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ARM_WIN   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_WIN  = 4'd3;

    // Start distance of the scan; a passing entry must beat it
    localparam int NO_MATCH_DIST = 1000000;
    localparam int NO_MATCH_W    = $clog2(NO_MATCH_DIST + 1);

    // Result index field
    localparam int OUT_IDX_W = 10;

    // Input kinds (s_tuser bit 0)
    localparam logic OP_LOG   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // s_tuser bit positions
    localparam int USER_OP        = 0;
    localparam int USER_LOG_START = 1;

    // Result status (m_tuser)
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STAT_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/gated_nearest_entry_lookup.sv =====
`default_nettype none

// Channel   Dir  Transfer on           Contents
// s_*       in   s_tvalid & s_tready   log line (learn) or query (pitch, yaw)
// m_*       out  m_tvalid & m_tready   one result per query: input, index, status
// cfg_*     in   cfg_we                window register write, no read-back
//
// A log line makes at most one memory write, at the fill pointer.
// A query scans the entry memory one entry per cycle on its single read
// port, or skips the scan when the table is empty. A finished scan also
// waits while an older result is held.
// The scan holds s_tready low; the result waits in the output register,
// and the next item may be taken while it waits for m_tready.
// Reset clears counters, history and windows; the entry memory is not
// cleared, as only entries below the fill count are ever read.
module gated_nearest_entry_lookup #(
    parameter int TABLE_DEPTH = gnel_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = gnel_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // Input stream
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // pitch, yaw, arm, base (low to high), zero padded
    input  wire logic [((4*VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,
    // op, log_start (low to high)
    input  wire logic [1:0]                               s_tuser,
    // Result stream
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // arm_out, base_out, best_index (low to high), zero padded
    output logic [((2*VALUE_WIDTH+gnel_pkg::OUT_IDX_W+7)/8)*8-1:0] m_tdata,
    // status
    output logic [gnel_pkg::STATUS_W-1:0]                 m_tuser,
    // Configuration
    input  wire logic                                     cfg_we,
    input  wire logic [gnel_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [gnel_pkg::WIN_W-1:0]               cfg_data
);
    import gnel_pkg::*;

    localparam int VW         = VALUE_WIDTH;
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int DIST_W     = VW + 2;
    localparam int DIFF_W     = (VW + 1 > WIN_W) ? VW + 1 : WIN_W;
    localparam int BEST_W     = (DIST_W > NO_MATCH_W) ? DIST_W : NO_MATCH_W;
    localparam int OUT_DATA_W = ((2*VW + OUT_IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - (2*VW + OUT_IDX_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    typedef struct packed {
        logic signed [VW-1:0] ib1_base;
        logic signed [VW-1:0] ib1_arm;
        logic signed [VW-1:0] in_base;
        logic signed [VW-1:0] in_arm;
        logic signed [VW-1:0] b2_yaw;
        logic signed [VW-1:0] b2_pitch;
        logic signed [VW-1:0] b1_yaw;
        logic signed [VW-1:0] b1_pitch;
        logic signed [VW-1:0] now_yaw;
        logic signed [VW-1:0] now_pitch;
    } entry_t;

    typedef struct packed {
        logic signed [VW-1:0] base;
        logic signed [VW-1:0] arm;
        logic signed [VW-1:0] yaw;
        logic signed [VW-1:0] pitch;
    } sample_t;

    // |a - b| of two signed values, zero extended for window compares
    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
        logic [VW:0] d;
        logic [VW:0] m;
        d = {a[VW-1], a} - {b[VW-1], b};
        m = d[VW] ? (~d + 1'b1) : d;
        return DIFF_W'(m);
    endfunction

    // Control and history
    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     entry_cnt_reg;
    logic [1:0]           line_cnt_reg;
    sample_t              log_b1_reg, log_b2_reg;
    logic signed [VW-1:0] prev_s1_pitch_reg, prev_s1_yaw_reg;
    logic signed [VW-1:0] prev_s2_pitch_reg, prev_s2_yaw_reg;
    logic signed [VW-1:0] prev_in_arm_reg, prev_in_base_reg;
    logic [WIN_W-1:0]     win_pitch_reg, win_yaw_reg, win_arm_reg, win_base_reg;
    logic signed [VW-1:0] q_pitch_reg, q_yaw_reg;

    // Scan pipeline
    logic [CNT_W-1:0]     issue_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    entry_t               mem_rdata_reg;
    logic                 s2_vld_reg, s2_pass_reg;
    logic [DIST_W-1:0]    s2_dist_reg;
    logic [IDX_W-1:0]     s2_idx_reg;
    logic signed [VW-1:0] s2_arm_reg, s2_base_reg;
    logic [BEST_W-1:0]    best_dist_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic signed [VW-1:0] res_arm_reg, res_base_reg;

    // Output register
    logic                  m_valid_reg;
    logic signed [VW-1:0]  out_arm_reg, out_base_reg;
    logic [OUT_IDX_W-1:0]  out_idx_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    // Input unpacking
    sample_t in_sample;
    logic    in_op, in_start;
    assign in_sample = s_tdata[4*VW-1:0];
    assign in_op     = s_tuser[USER_OP];
    assign in_start  = s_tuser[USER_LOG_START];

    logic s_xfer, log_xfer, query_xfer;
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign log_xfer   = s_xfer && (in_op == OP_LOG);
    assign query_xfer = s_xfer && (in_op == OP_QUERY);

    // Log line: store an entry from the third line of a log on
    logic [1:0] line_cnt_eff, line_cnt_next;
    logic       mem_we;
    entry_t     mem_wdata;
    always_comb
    begin
        line_cnt_eff  = in_start ? 2'd0 : line_cnt_reg;
        line_cnt_next = (line_cnt_eff < 2'd2) ? line_cnt_eff + 2'd1 : line_cnt_eff;
        mem_we        = log_xfer && (line_cnt_eff >= 2'd2)
                        && (entry_cnt_reg < CNT_W'(TABLE_DEPTH));
        mem_wdata.now_pitch = in_sample.pitch;
        mem_wdata.now_yaw   = in_sample.yaw;
        mem_wdata.b1_pitch  = log_b1_reg.pitch;
        mem_wdata.b1_yaw    = log_b1_reg.yaw;
        mem_wdata.b2_pitch  = log_b2_reg.pitch;
        mem_wdata.b2_yaw    = log_b2_reg.yaw;
        mem_wdata.in_arm    = in_sample.arm;
        mem_wdata.in_base   = in_sample.base;
        mem_wdata.ib1_arm   = log_b1_reg.arm;
        mem_wdata.ib1_base  = log_b1_reg.base;
    end

    // Entry memory: one write port (log lines), one read port (scan).
    // Writes only happen in idle, read data is only used during a scan: no overlap.
    entry_t mem [0:TABLE_DEPTH-1];
    logic   issuing;
    assign issuing = (state_reg == ST_SCAN) && (issue_reg < entry_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[entry_cnt_reg[IDX_W-1:0]] <= mem_wdata;
        end
        mem_rdata_reg <= mem[issue_reg[IDX_W-1:0]];
    end

    // Stage A: history gate and L1 distance of the entry just read
    logic              gate_pass;
    logic [DIST_W-1:0] l1_dist;
    always_comb
    begin
        gate_pass =
            (abs_diff(mem_rdata_reg.b1_pitch, prev_s1_pitch_reg) <= DIFF_W'(win_pitch_reg)) &&
            (abs_diff(mem_rdata_reg.b1_yaw,   prev_s1_yaw_reg)   <= DIFF_W'(win_yaw_reg))   &&
            (abs_diff(mem_rdata_reg.b2_pitch, prev_s2_pitch_reg) <= DIFF_W'(win_pitch_reg)) &&
            (abs_diff(mem_rdata_reg.b2_yaw,   prev_s2_yaw_reg)   <= DIFF_W'(win_yaw_reg))   &&
            (abs_diff(mem_rdata_reg.ib1_arm,  prev_in_arm_reg)   <= DIFF_W'(win_arm_reg))   &&
            (abs_diff(mem_rdata_reg.ib1_base, prev_in_base_reg)  <= DIFF_W'(win_base_reg));
        l1_dist = DIST_W'(abs_diff(mem_rdata_reg.now_pitch, q_pitch_reg))
                + DIST_W'(abs_diff(mem_rdata_reg.now_yaw,   q_yaw_reg));
    end

    // Stage B: strict less keeps the first entry on a tie
    logic better;
    assign better = s2_vld_reg && s2_pass_reg && (BEST_W'(s2_dist_reg) < best_dist_reg);

    // Result assembly
    logic                       out_load;
    logic [IDX_W+OUT_IDX_W-1:0] best_idx_ext;
    logic [STATUS_W-1:0]        status_next;
    assign out_load     = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign best_idx_ext = {{OUT_IDX_W{1'b0}}, best_idx_reg};

    always_comb
    begin
        if (entry_cnt_reg == '0)
        begin
            status_next = STAT_EMPTY;
        end
        else if (best_dist_reg < BEST_W'(NO_MATCH_DIST))
        begin
            status_next = STAT_FOUND;
        end
        else
        begin
            status_next = STAT_NONE;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_xfer)
                begin
                    state_next = (entry_cnt_reg == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issuing && !rd_vld_reg && !s2_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, history and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            entry_cnt_reg     <= '0;
            line_cnt_reg      <= 2'd0;
            log_b1_reg        <= '0;
            log_b2_reg        <= '0;
            prev_s1_pitch_reg <= '0;
            prev_s1_yaw_reg   <= '0;
            prev_s2_pitch_reg <= '0;
            prev_s2_yaw_reg   <= '0;
            prev_in_arm_reg   <= '0;
            prev_in_base_reg  <= '0;
            win_pitch_reg     <= WINDOW_RESET;
            win_yaw_reg       <= WINDOW_RESET;
            win_arm_reg       <= WINDOW_RESET;
            win_base_reg      <= WINDOW_RESET;
            issue_reg         <= '0;
            rd_vld_reg        <= 1'b0;
            s2_vld_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PITCH_WIN: win_pitch_reg <= cfg_data;
                    REG_YAW_WIN:   win_yaw_reg   <= cfg_data;
                    REG_ARM_WIN:   win_arm_reg   <= cfg_data;
                    REG_BASE_WIN:  win_base_reg  <= cfg_data;
                    default:       ;
                endcase
            end

            // Log history shift and table fill
            if (log_xfer)
            begin
                line_cnt_reg <= line_cnt_next;
                log_b2_reg   <= log_b1_reg;
                log_b1_reg   <= in_sample;
                if (mem_we)
                begin
                    entry_cnt_reg <= entry_cnt_reg + 1'b1;
                end
            end

            // Scan read issue
            if (query_xfer)
            begin
                issue_reg <= '0;
            end
            else if (issuing)
            begin
                issue_reg <= issue_reg + 1'b1;
            end
            rd_vld_reg <= issuing;
            s2_vld_reg <= rd_vld_reg;

            // Query history shift when the result is posted
            if (out_load)
            begin
                prev_s2_pitch_reg <= prev_s1_pitch_reg;
                prev_s2_yaw_reg   <= prev_s1_yaw_reg;
                prev_s1_pitch_reg <= q_pitch_reg;
                prev_s1_yaw_reg   <= q_yaw_reg;
                prev_in_arm_reg   <= res_arm_reg;
                prev_in_base_reg  <= res_base_reg;
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            q_pitch_reg <= in_sample.pitch;
            q_yaw_reg   <= in_sample.yaw;
        end

        rd_idx_reg <= issue_reg[IDX_W-1:0];

        s2_pass_reg <= gate_pass;
        s2_dist_reg <= l1_dist;
        s2_idx_reg  <= rd_idx_reg;
        s2_arm_reg  <= mem_rdata_reg.in_arm;
        s2_base_reg <= mem_rdata_reg.in_base;

        // Best so far; entry 0 is the fallback when nothing passes
        if (query_xfer)
        begin
            best_dist_reg <= BEST_W'(NO_MATCH_DIST);
            best_idx_reg  <= '0;
            res_arm_reg   <= '0;
            res_base_reg  <= '0;
        end
        else if (better)
        begin
            best_dist_reg <= BEST_W'(s2_dist_reg);
            best_idx_reg  <= s2_idx_reg;
            res_arm_reg   <= s2_arm_reg;
            res_base_reg  <= s2_base_reg;
        end
        else if (s2_vld_reg && (s2_idx_reg == '0))
        begin
            res_arm_reg  <= s2_arm_reg;
            res_base_reg <= s2_base_reg;
        end

        if (out_load)
        begin
            out_arm_reg    <= res_arm_reg;
            out_base_reg   <= res_base_reg;
            out_idx_reg    <= best_idx_ext[OUT_IDX_W-1:0];
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_idx_reg, out_base_reg, out_arm_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gnel_checker.sv =====
`default_nettype none

module gnel_checker #(
    parameter int VALUE_WIDTH = gnel_pkg::VALUE_WIDTH_DEF
) (
    input wire logic                                     clk,
    input wire logic                                     rst_n,
    input wire logic                                     s_tvalid,
    input wire logic                                     s_tready,
    input wire logic [1:0]                               s_tuser,
    input wire logic                                     m_tvalid,
    input wire logic                                     m_tready,
    input wire logic [((2*VALUE_WIDTH+gnel_pkg::OUT_IDX_W+7)/8)*8-1:0] m_tdata,
    input wire logic [gnel_pkg::STATUS_W-1:0]            m_tuser
);
    import gnel_pkg::*;

    localparam int IDX_LO = 2*VALUE_WIDTH;
    localparam int IDX_HI = 2*VALUE_WIDTH + OUT_IDX_W - 1;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its contents
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Empty table returns zero input and index
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_EMPTY) |-> (m_tdata[IDX_HI:0] == '0))
        else $error("empty-table result not zero");

    // Fallback result always points at entry 0
    a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_NONE) |-> (m_tdata[IDX_HI:IDX_LO] == '0))
        else $error("fallback result index not zero");

    // A query transfer blocks the input while the table is scanned
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[USER_OP] == OP_QUERY) |=> !s_tready)
        else $error("input taken during a scan");

endmodule

bind gated_nearest_entry_lookup gnel_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_gnel_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire

// ===== tb/sv/gated_nearest_entry_lookup_test.sv =====
localparam int SAMPLE_W    = gnel_pkg::VALUE_WIDTH_DEF;
localparam int ENTRY_DEPTH = gnel_pkg::TABLE_DEPTH_DEF;
localparam int DATA_W      = ((4*SAMPLE_W+7)/8)*8;
localparam int RESULT_W    = ((2*SAMPLE_W+gnel_pkg::OUT_IDX_W+7)/8)*8;
localparam int CFG_IDX_W   = gnel_pkg::CFG_INDEX_W;
localparam int WINDOW_W    = gnel_pkg::WIN_W;

typedef logic signed [SAMPLE_W-1:0] sample_t;

// One input transfer: log line or query
typedef struct {
    logic    op;
    logic    start;
    sample_t pitch;
    sample_t yaw;
    sample_t arm;
    sample_t base;
} lookup_item_t;

// One expected lookup answer
typedef struct {
    sample_t                            arm;
    sample_t                            base;
    logic [gnel_pkg::OUT_IDX_W-1:0]     index;
    logic [gnel_pkg::STATUS_W-1:0]      status;
} pick_t;

// Mirrors the entry table and query history; predicts and checks answers
class lookup_tracker;
    logic [gnel_pkg::WIN_W-1:0] window [4];
    sample_t cur_state   [ENTRY_DEPTH][2];
    sample_t back1_state [ENTRY_DEPTH][2];
    sample_t back2_state [ENTRY_DEPTH][2];
    sample_t cur_input   [ENTRY_DEPTH][2];
    sample_t back1_input [ENTRY_DEPTH][2];
    int unsigned entries;
    int unsigned line_count;
    sample_t line_back1 [4];
    sample_t line_back2 [4];
    sample_t last_query [2];
    sample_t older_query [2];
    sample_t last_pick [2];
    pick_t   pending_picks [$];
    int mismatches;
    int answers_checked;
    int log_lines, stored_lines, dropped_lines;
    int found_count, fallback_count, empty_count;

    function new();
        foreach (window[i]) window[i] = gnel_pkg::WINDOW_RESET;
        foreach (line_back1[i])
        begin
            line_back1[i] = '0;
            line_back2[i] = '0;
        end
        foreach (last_query[i])
        begin
            last_query[i]  = '0;
            older_query[i] = '0;
            last_pick[i]   = '0;
        end
        entries = 0;
        line_count = 0;
        mismatches = 0;
        answers_checked = 0;
        log_lines = 0;
        stored_lines = 0;
        dropped_lines = 0;
        found_count = 0;
        fallback_count = 0;
        empty_count = 0;
    endfunction

    function void set_window(logic [gnel_pkg::CFG_INDEX_W-1:0] index,
                             logic [gnel_pkg::WIN_W-1:0] value);
        // spare indexes hit no register
        if (index <= gnel_pkg::REG_BASE_WIN)
            window[index] = value;
    endfunction

    static function int unsigned spread(sample_t a, sample_t b);
        int x;
        int y;
        x = a;
        y = b;
        return (x > y) ? x - y : y - x;
    endfunction

    // Gated L1 scan over the table, then shift the query history
    function pick_t pick_nearest(sample_t pitch, sample_t yaw);
        pick_t       r;
        int unsigned best_dist;
        int unsigned d;
        int unsigned best;
        bit          ok;
        best_dist = gnel_pkg::NO_MATCH_DIST;
        best = 0;
        for (int unsigned k = 0; k < entries; k++)
        begin
            ok = spread(back1_state[k][0], last_query[0]) <= window[gnel_pkg::REG_PITCH_WIN]
              && spread(back1_state[k][1], last_query[1]) <= window[gnel_pkg::REG_YAW_WIN]
              && spread(back2_state[k][0], older_query[0]) <= window[gnel_pkg::REG_PITCH_WIN]
              && spread(back2_state[k][1], older_query[1]) <= window[gnel_pkg::REG_YAW_WIN]
              && spread(back1_input[k][0], last_pick[0]) <= window[gnel_pkg::REG_ARM_WIN]
              && spread(back1_input[k][1], last_pick[1]) <= window[gnel_pkg::REG_BASE_WIN];
            if (ok)
            begin
                d = spread(cur_state[k][0], pitch) + spread(cur_state[k][1], yaw);
                // strict compare keeps the first entry on a tie
                if (d < best_dist)
                begin
                    best_dist = d;
                    best = k;
                end
            end
        end
        if (entries == 0)
        begin
            r.status = gnel_pkg::STAT_EMPTY;
            r.arm = '0;
            r.base = '0;
            r.index = '0;
            empty_count++;
        end
        else
        begin
            if (best_dist < gnel_pkg::NO_MATCH_DIST)
            begin
                r.status = gnel_pkg::STAT_FOUND;
                found_count++;
            end
            else
            begin
                r.status = gnel_pkg::STAT_NONE;
                fallback_count++;
            end
            r.arm = cur_input[best][0];
            r.base = cur_input[best][1];
            r.index = best[gnel_pkg::OUT_IDX_W-1:0];
        end
        older_query = last_query;
        last_query[0] = pitch;
        last_query[1] = yaw;
        last_pick[0] = r.arm;
        last_pick[1] = r.base;
        return r;
    endfunction

    // Called once per accepted input transfer
    function void note_item(lookup_item_t it);
        if (it.op == gnel_pkg::OP_LOG)
        begin
            if (it.start)
                line_count = 0;
            if (line_count >= 2)
            begin
                if (entries < ENTRY_DEPTH)
                begin
                    cur_state[entries][0]   = it.pitch;
                    cur_state[entries][1]   = it.yaw;
                    back1_state[entries][0] = line_back1[0];
                    back1_state[entries][1] = line_back1[1];
                    back2_state[entries][0] = line_back2[0];
                    back2_state[entries][1] = line_back2[1];
                    cur_input[entries][0]   = it.arm;
                    cur_input[entries][1]   = it.base;
                    back1_input[entries][0] = line_back1[2];
                    back1_input[entries][1] = line_back1[3];
                    entries++;
                    stored_lines++;
                end
                else
                    dropped_lines++;
            end
            line_back2 = line_back1;
            line_back1[0] = it.pitch;
            line_back1[1] = it.yaw;
            line_back1[2] = it.arm;
            line_back1[3] = it.base;
            if (line_count < 2)
                line_count++;
            log_lines++;
        end
        else
            pending_picks = {pending_picks, pick_nearest(it.pitch, it.yaw)};
    endfunction

    task report_mismatch(string what);
        $display("lookup mismatch: %s", what);
        mismatches++;
    endtask

    // Called once per accepted result transfer
    task check_result(logic [RESULT_W-1:0] data, logic [gnel_pkg::STATUS_W-1:0] status);
        pick_t   want;
        sample_t arm;
        sample_t base;
        logic [gnel_pkg::OUT_IDX_W-1:0] index;
        arm = data[SAMPLE_W-1:0];
        base = data[2*SAMPLE_W-1:SAMPLE_W];
        index = data[2*SAMPLE_W +: gnel_pkg::OUT_IDX_W];
        if (pending_picks.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result arm %0d base %0d index %0d status %0d",
                                      arm, base, index, status));
            return;
        end
        want = pending_picks.pop_front();
        answers_checked++;
        if (arm !== want.arm)
            report_mismatch($sformatf("answer %0d arm_out %0d, expected %0d",
                                      answers_checked, arm, want.arm));
        if (base !== want.base)
            report_mismatch($sformatf("answer %0d base_out %0d, expected %0d",
                                      answers_checked, base, want.base));
        if (index !== want.index)
            report_mismatch($sformatf("answer %0d best_index %0d, expected %0d",
                                      answers_checked, index, want.index));
        if (status !== want.status)
            report_mismatch($sformatf("answer %0d status %0d, expected %0d",
                                      answers_checked, status, want.status));
    endtask
endclass

module gated_nearest_entry_lookup_test;

    localparam int HOLD_CYCLES = 400;
    localparam logic [gnel_pkg::CFG_INDEX_W-1:0] REG_FIRST_SPARE =
        CFG_IDX_W'(gnel_pkg::REG_BASE_WIN + 1);
    localparam logic [gnel_pkg::CFG_INDEX_W-1:0] CFG_INDEX_LAST  = '1;
    localparam sample_t V_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t V_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_style_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [RESULT_W-1:0] m_tdata;
    logic [gnel_pkg::STATUS_W-1:0] m_tuser;
    logic cfg_we;
    logic [gnel_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gnel_pkg::WIN_W-1:0] cfg_data;

    lookup_tracker tracker = new();
    int burst_left = 0;
    int settings_applied = 0;
    bit hold_off_req = 0;

    gated_nearest_entry_lookup dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser);
    end

    // Run limit
    initial
    begin
        #40000000;
        $display("gated_nearest_entry_lookup_test NOT OK");
        $finish;
    end

    // Receiver: rotating stall styles, plus one long hold-off on request
    initial
    begin
        int rx_cycle;
        rx_cycle = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 0;
            end
            else
            begin
                rx_cycle++;
                case (rx_style_t'((rx_cycle / 80) % 4))
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    // Sample values: mostly clustered near zero so windows pass often
    function automatic sample_t rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return sample_t'($urandom);
        if (r < 25)
            return sample_t'(int'($urandom_range(0, 400)) - 200);
        return sample_t'(int'($urandom_range(0, 40)) - 20);
    endfunction

    function automatic lookup_item_t next_random_item(int log_pct, int start_odds);
        lookup_item_t it;
        it.op = ($urandom_range(0, 99) < log_pct) ? gnel_pkg::OP_LOG : gnel_pkg::OP_QUERY;
        if (it.op == gnel_pkg::OP_LOG)
            it.start = ($urandom_range(0, start_odds - 1) == 0);
        else
            it.start = 1'($urandom_range(0, 1));
        it.pitch = rand_sample();
        it.yaw = rand_sample();
        it.arm = rand_sample();
        it.base = rand_sample();
        return it;
    endfunction

    // Sender: bursts of random length separated by random gaps
    task automatic send_item(lookup_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {it.base, it.arm, it.yaw, it.pitch};
        s_tuser <= {it.start, it.op};
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        tracker.note_item(it);
    endtask

    task automatic send_fields(logic op, logic start, sample_t p, sample_t y,
                               sample_t a, sample_t b);
        lookup_item_t it;
        it.op = op;
        it.start = start;
        it.pitch = p;
        it.yaw = y;
        it.arm = a;
        it.base = b;
        send_item(it);
    endtask

    task automatic run_random(int count, int log_pct);
        repeat (count) send_item(next_random_item(log_pct, 8));
    endtask

    // Stop offering, drain all answers, then cover a scan still in flight
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_picks.size() != 0) @(posedge clk);
        repeat (tracker.entries + 8) @(posedge clk);
    endtask

    // Four window writes, then one to an unused index
    task automatic apply_windows(logic [15:0] p, logic [15:0] y, logic [15:0] a,
                                 logic [15:0] b, logic [gnel_pkg::CFG_INDEX_W-1:0] spare);
        logic [gnel_pkg::CFG_INDEX_W-1:0] idxs [5];
        logic [gnel_pkg::WIN_W-1:0] vals [5];
        idxs[0] = gnel_pkg::REG_PITCH_WIN;
        idxs[1] = gnel_pkg::REG_YAW_WIN;
        idxs[2] = gnel_pkg::REG_ARM_WIN;
        idxs[3] = gnel_pkg::REG_BASE_WIN;
        idxs[4] = spare;
        vals[0] = p;
        vals[1] = y;
        vals[2] = a;
        vals[3] = b;
        vals[4] = WINDOW_W'($urandom);
        for (int i = 0; i < 5; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            tracker.set_window(idxs[i], vals[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [gnel_pkg::CFG_INDEX_W-1:0] spare_index();
        return CFG_IDX_W'($urandom_range(REG_FIRST_SPARE, CFG_INDEX_LAST));
    endfunction

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset windows, empty table, ignored query fields
        send_fields(gnel_pkg::OP_QUERY, 1'b1, V_MIN, V_MAX, V_MAX, V_MIN);
        send_fields(gnel_pkg::OP_QUERY, 1'b0, 0, 0, 0, 0);
        // lines before any log start form one log
        send_fields(gnel_pkg::OP_LOG, 1'b0, 0, 0, 0, 0);
        send_fields(gnel_pkg::OP_LOG, 1'b0, 0, 0, 0, 0);
        send_fields(gnel_pkg::OP_LOG, 1'b0, 0, 0, 0, 0);
        // old history is far away: the first query falls back to entry 0
        send_fields(gnel_pkg::OP_QUERY, 1'b0, 0, 0, 0, 0);
        send_fields(gnel_pkg::OP_QUERY, 1'b0, 3, 3, 0, 0);
        // extreme values in every field
        send_fields(gnel_pkg::OP_LOG, 1'b1, V_MAX, V_MAX, V_MAX, V_MAX);
        send_fields(gnel_pkg::OP_LOG, 1'b0, V_MIN, V_MIN, V_MIN, V_MIN);
        send_fields(gnel_pkg::OP_LOG, 1'b0, V_MAX, V_MIN, V_MIN, V_MAX);
        // repeated lines give identical entries: the first must win
        send_fields(gnel_pkg::OP_LOG, 1'b1, 1, 1, 2, 2);
        send_fields(gnel_pkg::OP_LOG, 1'b0, 1, 1, 2, 2);
        send_fields(gnel_pkg::OP_LOG, 1'b0, 1, 1, 2, 2);
        send_fields(gnel_pkg::OP_LOG, 1'b0, 1, 1, 2, 2);
        send_fields(gnel_pkg::OP_QUERY, 1'b0, 1, 1, 0, 0);
        send_fields(gnel_pkg::OP_QUERY, 1'b0, V_MAX, V_MIN, 0, 0);
        send_fields(gnel_pkg::OP_QUERY, 1'b0, -1, -1, 0, 0);
        // log start on a query has no effect
        send_fields(gnel_pkg::OP_QUERY, 1'b1, 1, 1, V_MIN, V_MAX);
        send_fields(gnel_pkg::OP_LOG, 1'b1, -5, -5, -3, -3);
        send_fields(gnel_pkg::OP_QUERY, 1'b0, -4, -4, 0, 0);

        // Random phases under different window settings
        run_random(112, 55);
        settle();
        apply_windows(16'd0, 16'd0, 16'd0, 16'd0, CFG_INDEX_LAST);
        hold_off_req = 1;
        run_random(112, 55);
        settle();
        apply_windows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, spare_index());
        run_random(112, 55);
        settle();
        apply_windows(WINDOW_W'($urandom), WINDOW_W'($urandom_range(0, 40)),
                      WINDOW_W'($urandom_range(0, 40)), WINDOW_W'($urandom),
                      spare_index());
        run_random(112, 55);
        settle();
        apply_windows(16'd5, 16'd40, 16'd0, 16'hFFFF, REG_FIRST_SPARE);
        run_random(112, 55);
        settle();

        $display("run: %0d log lines (%0d stored, %0d dropped on a full table), %0d queries",
                 tracker.log_lines, tracker.stored_lines, tracker.dropped_lines,
                 tracker.answers_checked);
        $display("answers: %0d matched, %0d fell back to entry 0, %0d on empty table; %0d window sets",
                 tracker.found_count, tracker.fallback_count, tracker.empty_count,
                 settings_applied + 1);
        if (tracker.mismatches == 0)
            $display("gated_nearest_entry_lookup_test OK");
        else
            $display("gated_nearest_entry_lookup_test NOT OK");
        $finish;
    end

endmodule
